### rtl/twvg_pkg.sv
// ----------------------------------------------------------------------------
// twvg_pkg: shared types and arithmetic helpers of the torus vertex generator
// Configuration, queue item and status types; divider step and Q1.14 rounding.
// ----------------------------------------------------------------------------
package twvg_pkg;

    localparam int MAX_RINGS    = 256;
    localparam int MAX_SEGMENTS = 256;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    // quarter-wave polynomial coefficients
    localparam logic [14:0] SIN_A = 15'd25718;
    localparam logic [13:0] SIN_B = 14'd10476;
    localparam logic [10:0] SIN_C = 11'd1142;

    typedef enum logic [1:0] {
        REG_MAJOR_RADIUS  = 2'd0,
        REG_MINOR_RADIUS  = 2'd1,
        REG_RING_COUNT    = 2'd2,
        REG_SEGMENT_COUNT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] major;
        logic [15:0] minor;
        logic [8:0]  rings;
        logic [8:0]  segs;
    } t_cfg;

    typedef struct packed {
        logic        err;
        logic [7:0]  ring;
        logic [7:0]  seg;
        logic [15:0] vidx;
        logic [15:0] rnb;
        logic [15:0] snb;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // four restoring-division steps: returns {remainder, quotient}
    function automatic logic [24:0] div_step4(input logic [8:0] rem_i,
                                              input logic [15:0] quo_i,
                                              input logic [8:0] den);
        logic [9:0]  t;
        logic [8:0]  rem;
        logic [15:0] quo;
        rem = rem_i;
        quo = quo_i;
        for (int k = 0; k < 4; k++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, den}) begin
                rem = 9'(t - {1'b0, den});
                quo = {quo[14:0], 1'b1};
            end else begin
                rem = t[8:0];
                quo = {quo[14:0], 1'b0};
            end
        end
        return {rem, quo};
    endfunction

    // drop 14 fraction bits, round half up, clamp to the coordinate range
    function automatic logic signed [17:0] round_q14(input logic signed [34:0] v);
        logic signed [35:0] x;
        logic signed [21:0] s;
        x = {v[34], v} + 36'sd8192;
        s = x[35:14];
        if (s > 22'sd131071) begin
            return 18'sd131071;
        end else if (s < -22'sd131071) begin
            return -18'sd131071;
        end
        return s[17:0];
    endfunction

endpackage

### rtl/torus_wireframe_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// torus_wireframe_vertex_generator_core: torus mesh vertex and edge generator
// Returns position, flat index and both wireframe neighbors of a vertex.
// ----------------------------------------------------------------------------
// One vertex request per clock is taken and one result per clock delivered
// while the output is not stalled. A request passes the intake register,
// the four-entry queue and the geometry pipeline: restoring division
// forming the angle, the sine polynomial (four serial multiplies per lane)
// and the coordinate products. Out-of-range requests return zero fields
// with the error flag in tuser. Write the registers only while no request
// is in flight.
module torus_wireframe_vertex_generator_core
    import twvg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [15:0]   s_axis_tdata,   // ring[7:0], segment[15:8]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,   // pos_x, pos_y, pos_z (18b each),
                                          // vertex_index, ring_neighbor,
                                          // segment_neighbor (16b each), 2b zero
    output logic          m_axis_tuser    // index_error
);

    t_cfg    r_cfg;
    t_item   f_item;
    t_item   q_item;
    t_q_stat q_stat;
    logic    f_push;
    logic    b_pop;

    logic signed [17:0] px;
    logic signed [17:0] py;
    logic signed [17:0] pz;
    logic [15:0] vidx;
    logic [15:0] rnb;
    logic [15:0] snb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.major <= 16'd512;
            r_cfg.minor <= 16'd128;
            r_cfg.rings <= 9'd16;
            r_cfg.segs  <= 9'd16;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAJOR_RADIUS:  r_cfg.major <= i_cfg_data;
                REG_MINOR_RADIUS:  r_cfg.minor <= i_cfg_data;
                REG_RING_COUNT:    r_cfg.rings <= i_cfg_data[8:0];
                REG_SEGMENT_COUNT: r_cfg.segs  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    twvg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_ring  (s_axis_tdata[7:0]),
        .i_seg   (s_axis_tdata[15:8]),
        .i_full  (q_stat.full),
        .o_push  (f_push),
        .o_item  (f_item)
    );

    twvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .i_pop   (b_pop),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    twvg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_avail (!q_stat.empty),
        .i_item  (q_item),
        .o_pop   (b_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_px    (px),
        .o_py    (py),
        .o_pz    (pz),
        .o_vidx  (vidx),
        .o_rnb   (rnb),
        .o_snb   (snb),
        .o_err   (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, snb, rnb, vidx, pz, py, px};

    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero fields");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty |-> !b_pop)
        else $error("pop from empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

### rtl/twvg_front.sv
// ----------------------------------------------------------------------------
// twvg_front: request intake
// Registers a request, checks its indices and forms the three vertex indices.
// ----------------------------------------------------------------------------
module twvg_front
    import twvg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_ring,
    input  logic [7:0]  i_seg,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    logic       r_vld;
    logic [7:0] r_ring;
    logic [7:0] r_seg;

    logic        err;
    logic [8:0]  nring;
    logic [8:0]  nseg;
    logic [16:0] prod_v;
    logic [17:0] prod_r;

    assign o_ready = !r_vld || !i_full;
    assign o_push  = r_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_ring <= i_ring;
            r_seg  <= i_seg;
        end
    end

    always_comb begin
        err = ({1'b0, r_ring} >= i_cfg.rings) || ({1'b0, r_seg} >= i_cfg.segs)
              || (int'(i_cfg.rings) > MAX_RINGS) || (int'(i_cfg.segs) > MAX_SEGMENTS);
        nring  = (9'({1'b0, r_ring} + 9'd1) >= i_cfg.rings) ? 9'd0
                                                             : 9'({1'b0, r_ring} + 9'd1);
        nseg   = (9'({1'b0, r_seg} + 9'd1) >= i_cfg.segs) ? 9'd0
                                                            : 9'({1'b0, r_seg} + 9'd1);
        prod_v = r_ring * i_cfg.segs;
        prod_r = nring * i_cfg.segs;
        o_item.err  = err;
        o_item.ring = r_ring;
        o_item.seg  = r_seg;
        o_item.vidx = 16'(prod_v + 17'(r_seg));
        o_item.rnb  = 16'(prod_r + 18'(r_seg));
        o_item.snb  = 16'(prod_v + 17'(nseg));
    end

endmodule

### rtl/twvg_queue.sv
// ----------------------------------------------------------------------------
// twvg_queue: short request queue
// Decouples the intake from the geometry pipeline.
// ----------------------------------------------------------------------------
module twvg_queue
    import twvg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### rtl/twvg_back.sv
// ----------------------------------------------------------------------------
// twvg_back: geometry pipeline
// Angle division, four sine lanes and the coordinate products; ten stages.
// ----------------------------------------------------------------------------
module twvg_back
    import twvg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_avail,
    input  t_item               i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [17:0]  o_px,
    output logic signed [17:0]  o_py,
    output logic signed [17:0]  o_pz,
    output logic [15:0]         o_vidx,
    output logic [15:0]         o_rnb,
    output logic [15:0]         o_snb,
    output logic                o_err
);

    localparam int NS = 10;

    logic        en;
    logic [NS-1:0] r_vld;
    t_item       r_meta [NS];

    // divider stages
    logic [8:0]  r_ra [4];
    logic [15:0] r_qa [4];
    logic [8:0]  r_rb [4];
    logic [15:0] r_qb [4];
    logic [24:0] n_da [4];
    logic [24:0] n_db [4];

    // sine lanes: sin a, cos a, sin b, cos b
    logic [16:0]        r_zz4 [4];
    logic [15:0]        r_z24 [4];
    logic               r_ng4 [4];
    logic [16:0]        r_zz5 [4];
    logic [15:0]        r_z25 [4];
    logic [13:0]        r_t5  [4];
    logic               r_ng5 [4];
    logic [16:0]        r_zz6 [4];
    logic [14:0]        r_u6  [4];
    logic               r_ng6 [4];
    logic signed [15:0] r_trig [4];

    logic signed [18:0] r_rr;
    logic signed [17:0] r_py8;
    logic signed [15:0] r_cb8;
    logic signed [15:0] r_sb8;

    logic signed [34:0] m8c;
    logic signed [34:0] m8s;
    logic signed [34:0] m9x;
    logic signed [34:0] m9z;

    assign en    = !r_vld[NS-1] || i_ready;
    assign o_pop = en && i_avail;

    assign n_da[0] = div_step4({1'b0, i_item.ring}, 16'd0, i_cfg.rings);
    assign n_db[0] = div_step4({1'b0, i_item.seg},  16'd0, i_cfg.segs);
    for (genvar k = 1; k < 4; k++) begin : g_div
        assign n_da[k] = div_step4(r_ra[k-1], r_qa[k-1], i_cfg.rings);
        assign n_db[k] = div_step4(r_rb[k-1], r_qb[k-1], i_cfg.segs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_avail};
        end
        if (en) begin
            r_meta[0] <= i_item;
            for (int s = 1; s < NS; s++) begin
                r_meta[s] <= r_meta[s-1];
            end
            for (int k = 0; k < 4; k++) begin
                r_ra[k] <= n_da[k][24:16];
                r_qa[k] <= n_da[k][15:0];
                r_rb[k] <= n_db[k][24:16];
                r_qb[k] <= n_db[k][15:0];
            end
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        logic [15:0] base;
        logic [15:0] ang;
        logic [16:0] zz;
        logic [33:0] m4;
        logic [26:0] m5;
        logic [29:0] m6;
        logic [31:0] m7;
        logic [14:0] s7;

        assign base = (l < 2) ? r_qa[3] : r_qb[3];
        assign ang  = ((l % 2) == 1) ? 16'(base + 16'd16384) : base;
        // odd quadrants run the quarter wave backward
        assign zz   = ang[14] ? 17'(17'd32768 - {2'b00, ang[13:0], 1'b0})
                              : {2'b00, ang[13:0], 1'b0};
        assign m4   = zz * zz;
        assign m5   = r_z24[l] * SIN_C;
        assign m6   = r_z25[l] * r_t5[l];
        assign m7   = r_zz6[l] * r_u6[l];
        assign s7   = m7[29:15];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_zz4[l] <= zz;
                r_z24[l] <= m4[30:15];
                r_ng4[l] <= ang[15];
                r_zz5[l] <= r_zz4[l];
                r_z25[l] <= r_z24[l];
                r_t5[l]  <= 14'(SIN_B - {2'b00, m5[26:15]});
                r_ng5[l] <= r_ng4[l];
                r_zz6[l] <= r_zz5[l];
                r_u6[l]  <= 15'(SIN_A - m6[29:15]);
                r_ng6[l] <= r_ng5[l];
                r_trig[l] <= r_ng6[l] ? -$signed({1'b0, s7}) : $signed({1'b0, s7});
            end
        end
    end

    assign m8c = 35'($signed({1'b0, i_cfg.minor}) * r_trig[1]);
    assign m8s = 35'($signed({1'b0, i_cfg.minor}) * r_trig[0]);
    assign m9x = 35'(r_rr * r_cb8);
    assign m9z = 35'(r_rr * r_sb8);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rr  <= $signed({3'b000, i_cfg.major}) + 19'(round_q14(m8c));
            r_py8 <= round_q14(m8s);
            r_cb8 <= r_trig[3];
            r_sb8 <= r_trig[2];
            // invalid requests report all-zero fields
            if (r_meta[8].err) begin
                o_px   <= '0;
                o_py   <= '0;
                o_pz   <= '0;
                o_vidx <= '0;
                o_rnb  <= '0;
                o_snb  <= '0;
            end else begin
                o_px   <= round_q14(m9x);
                o_py   <= r_py8;
                o_pz   <= round_q14(m9z);
                o_vidx <= r_meta[8].vidx;
                o_rnb  <= r_meta[8].rnb;
                o_snb  <= r_meta[8].snb;
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_err   = r_meta[NS-1].err;

endmodule

### dv/torus_wireframe_vertex_generator_core_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_wireframe_vertex_generator_core_chk: vertex result checker
// Tracks the register file and predicts each vertex result from its request.
// Compares every output transfer with the oldest pending vertex, field by field.
// ----------------------------------------------------------------------------
module torus_wireframe_vertex_generator_core_chk
    import twvg_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [15:0]  i_req_data,
    input  logic         i_vtx_valid,
    input  logic         i_vtx_ready,
    input  logic [103:0] i_vtx_data,
    input  logic         i_vtx_err,
    output int           o_mismatches,
    output int           o_pending
);

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [15:0]        vidx;
        logic [15:0]        rnb;
        logic [15:0]        snb;
        logic               err;
    } t_vertex;

    t_vertex     vertex_q[$];
    logic [15:0] major_r;
    logic [15:0] minor_r;
    logic [8:0]  ring_cnt;
    logic [8:0]  seg_cnt;

    function automatic longint quarter_wave(longint z);
        longint z2, t, u;
        z2 = (z * z) >>> 15;
        t  = 10476 - ((z2 * 1142) >>> 15);
        u  = 25718 - ((z2 * t) >>> 15);
        return (z * u) >>> 15;
    endfunction

    function automatic longint sine_q14(logic [15:0] p);
        longint z, s;
        z = longint'({p[13:0], 1'b0});
        if (p[14] == 1'b0) begin
            s = quarter_wave(z);
        end else begin
            s = quarter_wave(32768 - z);
        end
        return p[15] ? -s : s;
    endfunction

    function automatic longint drop_q14(longint v);
        longint x;
        x = v + 8192;
        if (x >= 0) begin
            return x >>> 14;
        end
        return -((-x + 16383) >>> 14);
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 131071) begin
            return 131071;
        end else if (v < -131071) begin
            return -131071;
        end
        return v;
    endfunction

    function automatic t_vertex predict_vertex(logic [7:0] ring, logic [7:0] seg);
        t_vertex     v;
        logic [15:0] pa, pb;
        longint      sa, ca, sb, cb, rc;
        int          nring, nseg;
        v = '{default: '0};
        if (ring >= ring_cnt || seg >= seg_cnt || ring_cnt > MAX_RINGS
            || seg_cnt > MAX_SEGMENTS) begin
            v.err = 1'b1;
            return v;
        end
        pa = 16'((longint'(ring) << 16) / ring_cnt);
        pb = 16'((longint'(seg) << 16) / seg_cnt);
        sa = sine_q14(pa);
        ca = sine_q14(pa + 16'd16384);
        sb = sine_q14(pb);
        cb = sine_q14(pb + 16'd16384);
        rc = longint'(major_r) + drop_q14(longint'(minor_r) * ca);
        v.x = 18'(clamp_coord(drop_q14(rc * cb)));
        v.y = 18'(clamp_coord(drop_q14(longint'(minor_r) * sa)));
        v.z = 18'(clamp_coord(drop_q14(rc * sb)));
        nring = (ring + 1 >= ring_cnt) ? 0 : ring + 1;
        nseg  = (seg + 1 >= seg_cnt) ? 0 : seg + 1;
        v.vidx = 16'(ring * seg_cnt + seg);
        v.rnb  = 16'(nring * seg_cnt + seg);
        v.snb  = 16'(ring * seg_cnt + nseg);
        return v;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_mismatches++;
        end
    endtask

    initial o_mismatches = 0;
    assign o_pending = vertex_q.size();

    always @(posedge i_clk) begin
        t_vertex e;
        if (!i_rst_n) begin
            major_r  <= 16'd512;
            minor_r  <= 16'd128;
            ring_cnt <= 9'd16;
            seg_cnt  <= 9'd16;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_MAJOR_RADIUS:  major_r  <= i_cfg_data;
                    REG_MINOR_RADIUS:  minor_r  <= i_cfg_data;
                    REG_RING_COUNT:    ring_cnt <= i_cfg_data[8:0];
                    REG_SEGMENT_COUNT: seg_cnt  <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                vertex_q.push_back(predict_vertex(i_req_data[7:0], i_req_data[15:8]));
            end
            if (i_vtx_valid && i_vtx_ready) begin
                if (vertex_q.size() == 0) begin
                    $error("vertex result with no request pending");
                    o_mismatches++;
                end else begin
                    e = vertex_q.pop_front();
                    check_field("pos_x", e.x, $signed(i_vtx_data[17:0]));
                    check_field("pos_y", e.y, $signed(i_vtx_data[35:18]));
                    check_field("pos_z", e.z, $signed(i_vtx_data[53:36]));
                    check_field("vertex_index", e.vidx, i_vtx_data[69:54]);
                    check_field("ring_neighbor", e.rnb, i_vtx_data[85:70]);
                    check_field("segment_neighbor", e.snb, i_vtx_data[101:86]);
                    check_field("pad", 0, i_vtx_data[103:102]);
                    check_field("index_error", e.err, i_vtx_err);
                end
            end
        end
    end

endmodule

### dv/torus_wireframe_vertex_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_wireframe_vertex_generator_core_tb: vertex generator testbench
// Drives vertex requests under several register settings with random gaps and
// output stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module torus_wireframe_vertex_generator_core_tb;
    import twvg_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 30;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tuser;
    int           mismatches;
    int           pending;
    int           idle_cycles = 0;
    int           vertices_seen = 0;
    bit           steady_feed = 1'b0;
    int           cur_rings = 16;
    int           cur_segs = 16;

    always #10 i_clk = ~i_clk;

    torus_wireframe_vertex_generator_core DUT (.*);

    torus_wireframe_vertex_generator_core_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_vtx_valid (m_axis_tvalid),
        .i_vtx_ready (m_axis_tready),
        .i_vtx_data  (m_axis_tdata),
        .i_vtx_err   (m_axis_tuser),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: random stalls, bursts of no stall, one long hold-off
    initial begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!held && vertices_seen >= 100) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                n = ((vertices_seen / 64) % 4 == 0) ? 0 : $urandom_range(0, 7);
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            vertices_seen++;
        end
    end

    task automatic send_request(logic [7:0] ring, logic [7:0] seg);
        int n;
        n = steady_feed ? 0 : $urandom_range(0, 7);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {seg, ring};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // finish the stream, wait for every result, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] major, logic [15:0] minor,
                            logic [15:0] rings, logic [15:0] segs);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MAJOR_RADIUS;
        i_cfg_data <= major;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MINOR_RADIUS;
        i_cfg_data <= minor;
        @(posedge i_clk);
        i_cfg_idx  <= REG_RING_COUNT;
        i_cfg_data <= rings;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SEGMENT_COUNT;
        i_cfg_data <= segs;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_rings = rings[8:0];
        cur_segs  = segs[8:0];
    endtask

    function automatic logic [7:0] pick_index(int cnt);
        if (cnt >= 1 && cnt <= 256 && $urandom_range(0, 9) != 0) begin
            return 8'($urandom_range(0, cnt - 1));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_burst(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) steady_feed = ($urandom_range(0, 3) == 0);
            send_request(pick_index(cur_rings), pick_index(cur_segs));
        end
        steady_feed = 1'b0;
    endtask

    initial begin
        logic [15:0] rc, sc;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: corners, wraps and out-of-range indices
        send_request(8'd0, 8'd0);
        send_request(8'd15, 8'd15);
        send_request(8'd15, 8'd0);
        send_request(8'd0, 8'd15);
        send_request(8'd16, 8'd0);
        send_request(8'd0, 8'd16);
        send_request(8'd255, 8'd255);
        send_request(8'd4, 8'd8);
        send_request(8'd12, 8'd3);
        drain();

        // largest radii and counts
        set_regs(16'hFFFF, 16'hFFFF, 16'd256, 16'd256);
        send_request(8'd0, 8'd0);
        send_request(8'd255, 8'd255);
        send_request(8'd64, 8'd192);
        send_request(8'd128, 8'd32);
        send_request(8'hAA, 8'h55);
        send_request(8'h55, 8'hAA);
        random_burst(150);
        drain();

        // single ring and segment, zero radii
        set_regs(16'd0, 16'd0, 16'd1, 16'd1);
        send_request(8'd0, 8'd0);
        send_request(8'd1, 8'd0);
        send_request(8'd0, 8'd1);
        drain();

        // zero counts and counts above the maximum
        set_regs(16'h1234, 16'h0400, 16'd0, 16'd8);
        send_request(8'd0, 8'd0);
        send_request(8'd3, 8'd3);
        drain();
        set_regs(16'h0800, 16'h0200, 16'd300, 16'hFFFF);
        send_request(8'd0, 8'd0);
        send_request(8'd200, 8'd100);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: rc = 16'd256;
                1: rc = 16'($urandom_range(0, 511));
                default: rc = 16'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 5))
                0: sc = 16'd256;
                1: sc = 16'($urandom_range(1, 256));
                default: sc = 16'($urandom_range(1, 40));
            endcase
            set_regs(16'($urandom()), 16'($urandom()), rc, sc);
            random_burst(140);
            drain();
        end

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/twvg_pkg.sv
rtl/twvg_front.sv
rtl/twvg_queue.sv
rtl/twvg_back.sv
rtl/torus_wireframe_vertex_generator_core.sv
dv/torus_wireframe_vertex_generator_core_chk.sv
dv/torus_wireframe_vertex_generator_core_tb.sv
